>>> rtl/lgtb_pkg.sv
// Shared types, widths, opcodes and the reciprocal table for the Legendre basis block.
// Used by lgtb_dp, lgtb_ctrl and the top level. No dependencies.
package lgtb_pkg;

   localparam int DEF_MAX_DEGREE = 8;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int COORD_W  = 18;
   localparam int DEGREE_W = 4;
   localparam int RESULT_W = 32;

   // internal fraction bits: polynomials, reciprocals, normalization constant
   localparam int IB = 24;
   localparam int RB = 30;
   localparam int CB = 26;

   localparam int RECIP_W = 32;
   localparam int RECIP_N = 16;
   localparam logic [RECIP_W-1:0] RECIP [RECIP_N] = '{
      32'd1073741824, 32'd536870912, 32'd357913941, 32'd268435456,
      32'd214748365,  32'd178956971, 32'd153391689, 32'd134217728,
      32'd119304647,  32'd107374182, 32'd97612893,  32'd89478485,
      32'd82595525,   32'd76695845,  32'd71582788,  32'd67108864
   };

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_START_X  = 4'd2;
   localparam logic [OP_W-1:0] OP_START_Y  = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_XP   = 4'd4;
   localparam logic [OP_W-1:0] OP_TERM     = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_R    = 4'd6;
   localparam logic [OP_W-1:0] OP_NEXT     = 4'd7;
   localparam logic [OP_W-1:0] OP_FIN_MUL  = 4'd8;
   localparam logic [OP_W-1:0] OP_FIN_RND  = 4'd9;
   localparam logic [OP_W-1:0] OP_FIN_MULC = 4'd10;
   localparam logic [OP_W-1:0] OP_FIN_CLIP = 4'd11;
   localparam logic [OP_W-1:0] OP_OUT_LOAD = 4'd12;

   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_BASIS  = 2'd0;
   localparam logic [SEL_W-1:0] SEL_GRAD_X = 2'd1;
   localparam logic [SEL_W-1:0] SEL_GRAD_Y = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEL_W-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic loop_done;
      logic root_done;
   } status_type;

endpackage

>>> rtl/lgtb_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Used by lgtb_dp for the normalization constant. No package dependency.
module lgtb_sqrt #(
   parameter int ROOT_W = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root,
   output logic                  done
);

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    rem_sh, trial;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;

   always_comb begin
      rem_sh  = {rem_ff[ROOT_W-1:0], rad_ff[2*ROOT_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = ~busy_ff;

endmodule

>>> rtl/lgtb_dp.sv
// Datapath: coordinate load, shared multiplier, recurrence, derivative sums, final scaling.
// Depends on lgtb_pkg and instantiates lgtb_sqrt.
module lgtb_dp #(
   parameter int MAX_DEGREE = lgtb_pkg::DEF_MAX_DEGREE,
   parameter int FRAC_BITS  = lgtb_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lgtb_pkg::cmd_type                     cmd,
   output lgtb_pkg::status_type                  status,
   input  logic signed [lgtb_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [lgtb_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [lgtb_pkg::DEGREE_W-1:0]         req_degree_x,
   input  logic [lgtb_pkg::DEGREE_W-1:0]         req_degree_y,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_basis_value,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_grad_x,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_grad_y,
   output logic                                  rsp_saturated
);

   localparam int IB       = lgtb_pkg::IB;
   localparam int RB       = lgtb_pkg::RB;
   localparam int CB       = lgtb_pkg::CB;
   localparam int RES_W    = lgtb_pkg::RESULT_W;
   localparam int DEG_W    = lgtb_pkg::DEGREE_W;
   localparam int DGW      = $clog2(MAX_DEGREE + 1);
   localparam int XW       = IB + 2;
   localparam int DW       = IB + 1 + $clog2(MAX_DEGREE * (MAX_DEGREE + 1) / 2 + 1);
   localparam int MW       = (DW + 1 > lgtb_pkg::RECIP_W) ? DW + 1 : lgtb_pkg::RECIP_W;
   localparam int PRW      = 2 * MW;
   localparam int ROOT_W   = DGW + CB;
   localparam int SQ_SHIFT = 2 * CB - 2;
   localparam int FS       = CB + IB - FRAC_BITS;
   localparam int RIDX_W   = $clog2(lgtb_pkg::RECIP_N);
   localparam int OW       = 2 * DGW + 2;

   localparam logic signed [XW-1:0]  ONE_IN     = XW'(2 ** FRAC_BITS);
   localparam logic signed [XW-1:0]  NEG_ONE_IN = -ONE_IN;
   localparam logic signed [XW-1:0]  ONE_Q      = XW'(2 ** IB);
   localparam logic [DEG_W:0]        MAX_D      = (DEG_W + 1)'(MAX_DEGREE);
   localparam logic signed [PRW-1:0] HALF_IB    = PRW'(1) <<< (IB - 1);
   localparam logic signed [PRW-1:0] HALF_RB    = PRW'(1) <<< (RB - 1);
   localparam logic signed [PRW-1:0] HALF_FS    = PRW'(1) <<< (FS - 1);
   localparam logic signed [PRW-1:0] RES_MAX    = PRW'({1'b0, {(RES_W - 1){1'b1}}});
   localparam logic signed [PRW-1:0] RES_MIN    = -RES_MAX - PRW'(1);

   logic signed [XW-1:0]    x_ff, y_ff, pcur_ff, pprev_ff, px_ff;
   logic signed [DW-1:0]    d_ff, dx_ff;
   logic [DGW-1:0]          ni_ff, nj_ff, k_ff;
   logic                    axis_ff;
   logic signed [MW-1:0]    t_ff, q_ff;
   logic signed [PRW-1:0]   prod_ff;
   logic [RES_W-1:0]        res_ff [3];
   logic                    sat_ff;

   logic signed [XW-1:0]    cx_ext, cy_ext, x_clamp, y_clamp;
   logic [DEG_W:0]          di_ext, dj_ext, di_clamp, dj_clamp;
   logic [DGW-1:0]          ni_load, nj_load, n_cur;
   logic [OW-1:0]           odd_prod;
   logic [2*ROOT_W-1:0]     radicand;
   logic [ROOT_W-1:0]       root;
   logic                    root_done;
   logic signed [DGW+1:0]   coef, kval;
   logic signed [DW-1:0]    dterm;
   logic signed [MW-1:0]    xp, t_next, mul_a, mul_b;
   logic signed [PRW-1:0]   mul_p, prod_r24, prod_r30, prod_rfs;
   logic                    clip_hi, clip_lo;
   logic [RES_W-1:0]        clip_val;

   always_comb begin
      cx_ext   = XW'(req_coord_x);
      cy_ext   = XW'(req_coord_y);
      x_clamp  = (cx_ext > ONE_IN) ? ONE_IN : ((cx_ext < NEG_ONE_IN) ? NEG_ONE_IN : cx_ext);
      y_clamp  = (cy_ext > ONE_IN) ? ONE_IN : ((cy_ext < NEG_ONE_IN) ? NEG_ONE_IN : cy_ext);
      di_ext   = {1'b0, req_degree_x};
      dj_ext   = {1'b0, req_degree_y};
      di_clamp = (di_ext > MAX_D) ? MAX_D : di_ext;
      dj_clamp = (dj_ext > MAX_D) ? MAX_D : dj_ext;
      ni_load  = DGW'(di_clamp);
      nj_load  = DGW'(dj_clamp);
      odd_prod = OW'({ni_load, 1'b1}) * OW'({nj_load, 1'b1});
      radicand = {odd_prod, {SQ_SHIFT{1'b0}}};
   end

   lgtb_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == lgtb_pkg::OP_LOAD),
      .radicand (radicand),
      .root     (root),
      .done     (root_done)
   );

   always_comb begin
      n_cur    = axis_ff ? nj_ff : ni_ff;
      coef     = $signed({1'b0, k_ff, 1'b1});
      kval     = $signed({2'b00, k_ff});
      dterm    = DW'(coef) * DW'(pcur_ff);
      prod_r24 = (prod_ff + HALF_IB) >>> IB;
      prod_r30 = (prod_ff + HALF_RB) >>> RB;
      prod_rfs = (prod_ff + HALF_FS) >>> FS;
      xp       = MW'(prod_r24);
      t_next   = MW'(coef) * xp - MW'(kval) * MW'(pprev_ff);
      clip_hi  = prod_rfs > RES_MAX;
      clip_lo  = prod_rfs < RES_MIN;
      clip_val = clip_hi ? RES_W'(RES_MAX) : (clip_lo ? RES_W'(RES_MIN) : RES_W'(prod_rfs));

      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         lgtb_pkg::OP_MUL_XP: begin
            mul_a = MW'(axis_ff ? y_ff : x_ff);
            mul_b = MW'(pcur_ff);
         end
         lgtb_pkg::OP_MUL_R: begin
            mul_a = t_ff;
            mul_b = MW'(lgtb_pkg::RECIP[RIDX_W'(k_ff)]);
         end
         lgtb_pkg::OP_FIN_MUL: begin
            case (cmd.sel)
               lgtb_pkg::SEL_BASIS: begin
                  mul_a = MW'(px_ff);
                  mul_b = MW'(pcur_ff);
               end
               lgtb_pkg::SEL_GRAD_X: begin
                  mul_a = MW'(dx_ff);
                  mul_b = MW'(pcur_ff);
               end
               default: begin
                  mul_a = MW'(px_ff);
                  mul_b = MW'(d_ff);
               end
            endcase
         end
         lgtb_pkg::OP_FIN_MULC: begin
            mul_a = MW'(root);
            mul_b = q_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         lgtb_pkg::OP_LOAD: begin
            x_ff   <= x_clamp <<< (IB - FRAC_BITS);
            y_ff   <= y_clamp <<< (IB - FRAC_BITS);
            ni_ff  <= ni_load;
            nj_ff  <= nj_load;
            sat_ff <= 1'b0;
         end
         lgtb_pkg::OP_START_X: begin
            axis_ff  <= 1'b0;
            k_ff     <= '0;
            pcur_ff  <= ONE_Q;
            pprev_ff <= '0;
            d_ff     <= '0;
         end
         lgtb_pkg::OP_START_Y: begin
            px_ff    <= pcur_ff;
            dx_ff    <= d_ff;
            axis_ff  <= 1'b1;
            k_ff     <= '0;
            pcur_ff  <= ONE_Q;
            pprev_ff <= '0;
            d_ff     <= '0;
         end
         lgtb_pkg::OP_MUL_XP: begin
            prod_ff <= mul_p;
            if (n_cur[0] ^ k_ff[0]) begin
               d_ff <= d_ff + dterm;
            end
         end
         lgtb_pkg::OP_TERM: begin
            t_ff <= t_next;
         end
         lgtb_pkg::OP_MUL_R: begin
            prod_ff <= mul_p;
         end
         lgtb_pkg::OP_NEXT: begin
            pprev_ff <= pcur_ff;
            pcur_ff  <= XW'(prod_r30);
            k_ff     <= k_ff + 1'b1;
         end
         lgtb_pkg::OP_FIN_MUL: begin
            prod_ff <= mul_p;
         end
         lgtb_pkg::OP_FIN_RND: begin
            q_ff <= xp;
         end
         lgtb_pkg::OP_FIN_MULC: begin
            prod_ff <= mul_p;
         end
         lgtb_pkg::OP_FIN_CLIP: begin
            res_ff[cmd.sel] <= clip_val;
            if (clip_hi || clip_lo) begin
               sat_ff <= 1'b1;
            end
         end
         lgtb_pkg::OP_OUT_LOAD: begin
            rsp_basis_value <= res_ff[lgtb_pkg::SEL_BASIS];
            rsp_grad_x      <= res_ff[lgtb_pkg::SEL_GRAD_X];
            rsp_grad_y      <= res_ff[lgtb_pkg::SEL_GRAD_Y];
            rsp_saturated   <= sat_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.loop_done = (k_ff == n_cur);
   assign status.root_done = root_done;

endmodule

>>> rtl/lgtb_ctrl.sv
// Controller: sequences load, both recurrences, the final scaling and the output handshake.
// Depends on lgtb_pkg; drives lgtb_dp through cmd_type and reads status_type.
module lgtb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lgtb_pkg::cmd_type     cmd,
   input  lgtb_pkg::status_type  status
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
   localparam logic [ST_W-1:0] S_START_X   = 4'd1;
   localparam logic [ST_W-1:0] S_START_Y   = 4'd2;
   localparam logic [ST_W-1:0] S_CHECK     = 4'd3;
   localparam logic [ST_W-1:0] S_MUL_XP    = 4'd4;
   localparam logic [ST_W-1:0] S_TERM      = 4'd5;
   localparam logic [ST_W-1:0] S_MUL_R     = 4'd6;
   localparam logic [ST_W-1:0] S_NEXT      = 4'd7;
   localparam logic [ST_W-1:0] S_WAIT_ROOT = 4'd8;
   localparam logic [ST_W-1:0] S_FIN_MUL   = 4'd9;
   localparam logic [ST_W-1:0] S_FIN_RND   = 4'd10;
   localparam logic [ST_W-1:0] S_FIN_MULC  = 4'd11;
   localparam logic [ST_W-1:0] S_FIN_CLIP  = 4'd12;
   localparam logic [ST_W-1:0] S_OUT       = 4'd13;

   logic [ST_W-1:0]                state_ff, state_in;
   logic                           axis_ff, axis_in;
   logic [lgtb_pkg::SEL_W-1:0]     sel_ff, sel_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = lgtb_pkg::OP_NOP;
      cmd.sel      = sel_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = lgtb_pkg::OP_LOAD;
               state_in = S_START_X;
            end
         end
         S_START_X: begin
            cmd.op   = lgtb_pkg::OP_START_X;
            axis_in  = 1'b0;
            state_in = S_CHECK;
         end
         S_START_Y: begin
            cmd.op   = lgtb_pkg::OP_START_Y;
            axis_in  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.loop_done) begin
               state_in = axis_ff ? S_WAIT_ROOT : S_START_Y;
            end else begin
               state_in = S_MUL_XP;
            end
         end
         S_MUL_XP: begin
            cmd.op   = lgtb_pkg::OP_MUL_XP;
            state_in = S_TERM;
         end
         S_TERM: begin
            cmd.op   = lgtb_pkg::OP_TERM;
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            cmd.op   = lgtb_pkg::OP_MUL_R;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.op   = lgtb_pkg::OP_NEXT;
            state_in = S_CHECK;
         end
         S_WAIT_ROOT: begin
            if (status.root_done) begin
               sel_in   = lgtb_pkg::SEL_BASIS;
               state_in = S_FIN_MUL;
            end
         end
         S_FIN_MUL: begin
            cmd.op   = lgtb_pkg::OP_FIN_MUL;
            state_in = S_FIN_RND;
         end
         S_FIN_RND: begin
            cmd.op   = lgtb_pkg::OP_FIN_RND;
            state_in = S_FIN_MULC;
         end
         S_FIN_MULC: begin
            cmd.op   = lgtb_pkg::OP_FIN_MULC;
            state_in = S_FIN_CLIP;
         end
         S_FIN_CLIP: begin
            cmd.op = lgtb_pkg::OP_FIN_CLIP;
            if (sel_ff == lgtb_pkg::SEL_GRAD_Y) begin
               state_in = S_OUT;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = S_FIN_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = lgtb_pkg::OP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         sel_ff       <= lgtb_pkg::SEL_BASIS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/legendre_tensor_basis_with_gradient_top.sv
// Timing: the recurrence steps grow with i and j, the clamped degrees, and the final scaling
// waits for the bit-serial square root, which sets the least time from acceptance to rsp_valid.
// Throughput: one transaction at a time, with the recurrence steps sharing one multiplier;
// the next request can be taken in the cycle after the result loads, while the receiver keeps up.
// Reset: synchronous, active high; clears the controller and the root unit only.
module legendre_tensor_basis_with_gradient_top #(
   parameter int MAX_DEGREE = lgtb_pkg::DEF_MAX_DEGREE,
   parameter int FRAC_BITS  = lgtb_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [lgtb_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [lgtb_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [lgtb_pkg::DEGREE_W-1:0]         req_degree_x,
   input  logic [lgtb_pkg::DEGREE_W-1:0]         req_degree_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_basis_value,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_grad_x,
   output logic signed [lgtb_pkg::RESULT_W-1:0]  rsp_grad_y,
   output logic                                  rsp_saturated
);

   lgtb_pkg::cmd_type    cmd;
   lgtb_pkg::status_type status;

   lgtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lgtb_dp #(
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_degree_x    (req_degree_x),
      .req_degree_y    (req_degree_y),
      .rsp_basis_value (rsp_basis_value),
      .rsp_grad_x      (rsp_grad_x),
      .rsp_grad_y      (rsp_grad_y),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
